// File: rtl/core/qrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qrt_pkg;

    localparam int FIELD_W = 32;
    localparam int WIDTH   = 32;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [WIDTH-1:0]   word_t;

    typedef struct packed {
        word_t r;
        word_t x;
        word_t b;
    } mul_t;

    typedef struct packed {
        logic  valid;
        logic  zero;
        logic  mzero;
        word_t m;
        word_t e;
        word_t acc;
        word_t base;
    } meta_t;

endpackage

`default_nettype wire

// File: rtl/core/qrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module qrt_cell (
    input  wire logic          clk,
    input  wire qrt_pkg::mul_t d,
    input  wire qrt_pkg::word_t m,
    output qrt_pkg::mul_t      q
);
    import qrt_pkg::*;

    logic [WIDTH+1:0] s;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    word_t            b_sel;
    mul_t             q_next;
    mul_t             q_reg;

    // one bit of interleaved multiply, remainder kept below m
    always_comb
    begin
        b_sel  = d.x[WIDTH-1] ? d.b : '0;
        s      = {1'b0, d.r, 1'b0} + {2'b00, b_sel};
        m1     = {2'b00, m};
        m2     = {1'b0, m, 1'b0};
        q_next = d;
        if (s >= m2)
        begin
            q_next.r = WIDTH'(s - m2);
        end
        else if (s >= m1)
        begin
            q_next.r = WIDTH'(s - m1);
        end
        else
        begin
            q_next.r = WIDTH'(s);
        end
        q_next.x = d.x << 1;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/qrt_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module qrt_reduce (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire qrt_pkg::meta_t din,
    output qrt_pkg::meta_t      dout
);
    import qrt_pkg::*;

    mul_t  c [WIDTH+1];
    meta_t meta_reg [WIDTH];
    logic  valid_reg [WIDTH];
    word_t m_at [WIDTH];

    // value * 1 mod m, one value bit per cell
    assign c[0] = '{r: '0, x: din.base, b: WIDTH'(1)};

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign m_at[i] = din.m;
        end
        else
        begin : g_next
            assign m_at[i] = meta_reg[i-1].m;
        end

        qrt_cell u_cell (
            .clk (clk),
            .d   (c[i]),
            .m   (m_at[i]),
            .q   (c[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= din.valid;
            for (int i = 1; i < WIDTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= din;
        for (int i = 1; i < WIDTH; i++)
        begin
            meta_reg[i] <= meta_reg[i-1];
        end
    end

    always_comb
    begin
        dout       = meta_reg[WIDTH-1];
        dout.valid = valid_reg[WIDTH-1];
        dout.base  = c[WIDTH].r;
    end

endmodule

`default_nettype wire

// File: rtl/core/qrt_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module qrt_exp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire qrt_pkg::meta_t din,
    output qrt_pkg::meta_t      dout
);
    import qrt_pkg::*;

    mul_t  ca [WIDTH+1];
    mul_t  cb [WIDTH+1];
    meta_t meta_reg [WIDTH];
    logic  valid_reg [WIDTH];
    word_t m_at [WIDTH];

    // acc * base and base * base side by side
    assign ca[0] = '{r: '0, x: din.acc,  b: din.base};
    assign cb[0] = '{r: '0, x: din.base, b: din.base};

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign m_at[i] = din.m;
        end
        else
        begin : g_next
            assign m_at[i] = meta_reg[i-1].m;
        end

        qrt_cell u_cell_a (
            .clk (clk),
            .d   (ca[i]),
            .m   (m_at[i]),
            .q   (ca[i+1])
        );

        qrt_cell u_cell_b (
            .clk (clk),
            .d   (cb[i]),
            .m   (m_at[i]),
            .q   (cb[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= din.valid;
            for (int i = 1; i < WIDTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= din;
        for (int i = 1; i < WIDTH; i++)
        begin
            meta_reg[i] <= meta_reg[i-1];
        end
    end

    always_comb
    begin
        dout       = meta_reg[WIDTH-1];
        dout.valid = valid_reg[WIDTH-1];
        dout.acc   = meta_reg[WIDTH-1].e[0] ? ca[WIDTH].r : meta_reg[WIDTH-1].acc;
        dout.base  = cb[WIDTH].r;
        dout.e     = meta_reg[WIDTH-1].e >> 1;
    end

endmodule

`default_nettype wire

// File: rtl/core/quadratic_residue_test.sv
// channel   ports                      handshake
// input     value, modulus             start high while busy low
// result    is_square                  strobe high for one cycle
//
// one word enters every cycle; busy is never raised
// a word passes through the registered row of bit-serial modular multiply cells
// that reduce the value, then through a row of such cells per exponent bit, and
// last through the output register
// reset clears only the valid line; the receiver cannot stall the result
`timescale 1ns / 1ps
`default_nettype none

module quadratic_residue_test (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire qrt_pkg::field_t value,
    input  wire qrt_pkg::field_t modulus,
    output logic                 strobe,
    output logic                 is_square
);
    import qrt_pkg::*;

    meta_t head;
    meta_t stage [WIDTH+1];
    word_t v;
    word_t m;
    logic  strobe_reg;
    logic  is_square_reg;
    logic  is_square_next;

    assign v    = value[WIDTH-1:0];
    assign m    = modulus[WIDTH-1:0];
    assign busy = 1'b0;

    always_comb
    begin
        head.valid = start & ~busy;
        head.zero  = (v == '0);
        head.mzero = (m == '0);
        head.m     = m;
        head.e     = (m - WIDTH'(1)) >> 1;
        head.acc   = WIDTH'(1);
        head.base  = v;
    end

    qrt_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (head),
        .dout  (stage[0])
    );

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_exp
        qrt_exp u_exp (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (stage[i]),
            .dout  (stage[i+1])
        );
    end

    assign is_square_next = stage[WIDTH].zero |
                            (~stage[WIDTH].mzero & (stage[WIDTH].acc == WIDTH'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= stage[WIDTH].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        is_square_reg <= is_square_next;
    end

    assign strobe    = strobe_reg;
    assign is_square = is_square_reg;

endmodule

`default_nettype wire

// File: tb/quadratic_residue_test_tb.sv
`timescale 1ns / 1ps

module quadratic_residue_test_tb;

    import qrt_pkg::*;

    localparam int LATENCY = 1 + WIDTH + WIDTH * WIDTH;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    field_t value;
    field_t modulus;
    logic   strobe;
    logic   is_square;

    logic   busy_s;
    bit     square_q[$];
    int     mismatches;
    bit     idle_ok;

    longint unsigned primes[10] = '{3, 5, 7, 13, 65521, 65537, 1000003,
                                    2147483647, 4294967291, 4294967279};

    quadratic_residue_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .modulus   (modulus),
        .strobe    (strobe),
        .is_square (is_square)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        busy_s <= busy;

    function automatic bit euler_residue(field_t v, field_t m);
        longint unsigned e;
        longint unsigned acc;
        longint unsigned b;
        longint unsigned mm;
        if (v == '0)
            return 1'b1;
        if (m == '0)
            return 1'b0;
        mm  = m;
        e   = (mm - 1) >> 1;
        acc = 1;
        b   = v % mm;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (e[i])
                acc = (acc * b) % mm;
            b = (b * b) % mm;
        end
        return acc == 1;
    endfunction

    // drive one word and hold it until taken
    task automatic send_word(field_t v, field_t m);
        start   <= 1'b1;
        value   <= v;
        modulus <= m;
        do
            @(posedge clk);
        while (busy_s);
        square_q = {square_q, euler_residue(v, m)};
    endtask

    task automatic maybe_idle();
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic field_t pick_modulus();
        case ($urandom_range(0, 4))
            0, 1:    return field_t'(primes[$urandom_range(0, 9)]);
            2:       return field_t'($urandom_range(1, 300));
            3:       return field_t'($urandom | 1);
            default: return field_t'(($urandom == 0) ? 1 : $urandom);
        endcase
    endfunction

    function automatic field_t pick_value(field_t m);
        case ($urandom_range(0, 5))
            0:       return field_t'(m * $urandom_range(0, 3));
            1:       return field_t'($urandom_range(0, 20));
            2:       return field_t'(m - 1);
            default: return field_t'($urandom);
        endcase
    endfunction

    task automatic test_special_cases();
        send_word(32'd0, 32'd4294967291);
        send_word(32'd0, 32'd1);
        send_word(32'd7, 32'd7);
        send_word(32'd14, 32'd7);
        send_word(32'd1, 32'd7);
        send_word(32'd2, 32'd7);
        send_word(32'd3, 32'd7);
        send_word(32'hffff_ffff, 32'd1);
        send_word(32'h1234_5678, 32'd2);
        send_word(32'd0, 32'd2);
        send_word(32'hffff_ffff, 32'd4294967291);
        send_word(32'd4294967290, 32'd4294967291);
        send_word(32'd1, 32'd4294967291);
        send_word(32'hffff_ffff, 32'hffff_ffff);
        send_word(32'd5, 32'hffff_ffff);
        send_word(32'hffff_fffe, 32'hffff_ffff);
        send_word(32'h8000_0000, 32'd2147483647);
        send_word(32'd4, 32'd10);
        send_word(32'd65520, 32'd65521);
        send_word(32'hAAAA_5555, 32'h5555_AAAB);
    endtask

    task automatic test_random_mix(int count);
        field_t m;
        for (int i = 0; i < count; i++)
        begin
            maybe_idle();
            m = pick_modulus();
            send_word(pick_value(m), m);
        end
    endtask

    task automatic test_back_to_back(int count);
        field_t m;
        idle_ok = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            m = pick_modulus();
            send_word(pick_value(m), m);
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (square_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: is_square=%0b", is_square);
            end
            else
            begin
                if (is_square !== square_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("is_square mismatch: expected %0b actual %0b",
                                 square_q[0], is_square);
                end
                void'(square_q.pop_front());
            end
        end
    end

    initial
    begin
        mismatches = 0;
        idle_ok    = 1'b1;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        modulus    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random_mix(450);
        test_back_to_back(150);
        while (square_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY / 4 + 20) @(posedge clk);
        if (mismatches == 0 && square_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/qrt_pkg.sv
rtl/core/qrt_cell.sv
rtl/core/qrt_reduce.sv
rtl/core/qrt_exp.sv
rtl/core/quadratic_residue_test.sv
tb/quadratic_residue_test_tb.sv
